[hw/rtl/thread_runtime_energy_share_defines.svh]
// Assertion macros used by the checker file of the energy share block.
`ifndef THREAD_RUNTIME_ENERGY_SHARE_DEFINES_SVH
`define THREAD_RUNTIME_ENERGY_SHARE_DEFINES_SVH

// Check a property on every rising edge outside reset.
`define TRS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a stalled beat keeps its valid and its payload.
`define TRS_ASSERT_HOLD(lbl, clk, rst_n, vld, rdy, sig, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) \
		(vld && !rdy) |=> (vld && $stable(sig))) else $error(msg);

`endif

[hw/rtl/trs_pkg.sv]
// Types and constants of the thread runtime energy share block.
`default_nettype none
package trs_pkg;

	localparam logic [1:0] STATUS_FOUND = 2'd0;
	localparam logic [1:0] STATUS_NEW   = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	localparam logic [16:0] ONE_Q16 = 17'd65536;

	localparam logic [3:0] ADDR_CPU_COUNT   = 4'd0;
	localparam logic [3:0] ADDR_RUNTIME_INT = 4'd4;
	localparam logic [3:0] ADDR_REPORT_THR  = 4'd8;

	localparam logic [10:0] CPU_COUNT_RST   = 11'd1;
	localparam logic [31:0] RUNTIME_INT_RST = 32'd1000000;
	localparam logic [16:0] REPORT_THR_RST  = 17'd3277;

	typedef struct packed {
		logic [30:0]        thread_id;
		logic [63:0]        runtime_now;
		logic signed [31:0] energy_delta;
	} sample_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [16:0]        busy_fraction;
		logic signed [31:0] energy_share;
		logic               report;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_PLACE,
		ST_FRAC_DIV,
		ST_MUL,
		ST_SHARE_GO,
		ST_SHARE_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load_in;
		logic search_step;
		logic place;
		logic frac_div_start;
		logic frac_one;
		logic frac_take;
		logic mul;
		logic share_div_start;
		logic share_take;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic found;
		logic exhausted;
		logic full;
		logic delta_ge;
		logic div_idle;
	} sts_t;

endpackage
`default_nettype wire

[hw/rtl/thread_runtime_energy_share.sv]
// Top level of the thread runtime energy share block.
// One sample is worked at a time. The slot table is scanned linearly through
// a single memory read port, one slot per cycle. F is the number of slots
// taken so far, at most THREAD_SLOTS, and the scan reads at most F slots; a
// thread found early in the table ends the scan sooner. After the lookup the
// block places the slot, then runs the busy fraction divider (skipped when
// the fraction clamps to 1.0), then the multiply and the division by the
// CPU count, and then loads the result. A full table skips the divisions and
// the multiply and loads its result after the scan and the placing step. The
// result sits in an output register, and a result that is not taken holds
// the block before the load. The next sample is taken once the block
// returns to idle.
`default_nettype none
module thread_runtime_energy_share import trs_pkg::*; #(
	parameter int THREAD_SLOTS = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        sample_valid,
	output logic             sample_ready,
	input  wire sample_t     sample,
	output logic             result_valid,
	input  wire logic        result_ready,
	output result_t          result,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	logic [10:0] cpu_count_q;
	logic [31:0] runtime_int_q;
	logic [16:0] report_thr_q;
	logic        wr_en;
	cmd_t        cmd;
	sts_t        sts;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpu_count_q   <= CPU_COUNT_RST;
			runtime_int_q <= RUNTIME_INT_RST;
			report_thr_q  <= REPORT_THR_RST;
		end else if (wr_en) begin
			case (paddr)
				ADDR_CPU_COUNT:   cpu_count_q   <= pwdata[10:0];
				ADDR_RUNTIME_INT: runtime_int_q <= pwdata;
				ADDR_REPORT_THR:  report_thr_q  <= pwdata[16:0];
				default: begin
				end
			endcase
		end
	end

	// Register read back
	always_comb begin
		case (paddr)
			ADDR_CPU_COUNT:   prdata = {21'd0, cpu_count_q};
			ADDR_RUNTIME_INT: prdata = runtime_int_q;
			ADDR_REPORT_THR:  prdata = {15'd0, report_thr_q};
			default:          prdata = '0;
		endcase
	end

	trs_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.sts          (sts),
		.cmd          (cmd)
	);

	trs_datapath #(
		.THREAD_SLOTS (THREAD_SLOTS)
	) u_dp (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cmd                  (cmd),
		.sts                  (sts),
		.sample               (sample),
		.cpu_count            (cpu_count_q),
		.runtime_per_interval (runtime_int_q),
		.report_threshold     (report_thr_q),
		.result               (result)
	);
endmodule
`default_nettype wire

[hw/rtl/trs_div.sv]
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module trs_div import trs_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] dividend,
	input  wire logic [31:0] rem_init,
	input  wire logic [31:0] divisor,
	input  wire logic [5:0]  steps,
	output logic [31:0]      quotient,
	output logic             idle
);
	logic [31:0] rem_q;
	logic [31:0] dvd_q;
	logic [31:0] dvs_q;
	logic [31:0] quo_q;
	logic [5:0]  cnt_q;
	logic [32:0] trial;
	logic        take;
	logic [32:0] diff;

	// Shift the next dividend bit into the partial remainder
	always_comb begin
		trial = {rem_q, dvd_q[31]};
		take  = trial >= {1'b0, dvs_q};
		diff  = trial - {1'b0, dvs_q};
	end

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= steps;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	// Advance remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			dvd_q <= dividend;
			dvs_q <= divisor;
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q <= take ? diff[31:0] : trial[31:0];
			dvd_q <= {dvd_q[30:0], 1'b0};
			quo_q <= {quo_q[30:0], take};
		end
	end

	assign quotient = quo_q;
	assign idle     = (cnt_q == '0);
endmodule
`default_nettype wire

[hw/rtl/trs_datapath.sv]
// Slot table, runtime delta, busy fraction and energy share datapath.
`default_nettype none
module trs_datapath import trs_pkg::*; #(
	parameter int THREAD_SLOTS = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cmd_t        cmd,
	output sts_t             sts,
	input  wire sample_t     sample,
	input  wire logic [10:0] cpu_count,
	input  wire logic [31:0] runtime_per_interval,
	input  wire logic [16:0] report_threshold,
	output result_t          result
);
	localparam int AW = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
	localparam int CW = $clog2(THREAD_SLOTS + 1);
	localparam logic [CW-1:0] SLOTS_C = CW'(THREAD_SLOTS);

	logic [94:0]        mem [THREAD_SLOTS];
	logic [94:0]        rd_data_s1;
	logic               rd_vld_s1;
	logic [AW-1:0]      rd_addr_s1;
	logic [CW-1:0]      idx_q;
	logic [CW-1:0]      fill_q;
	logic [30:0]        tid_q;
	logic [63:0]        now_q;
	logic signed [31:0] energy_q;
	logic [AW-1:0]      slot_q;
	logic [63:0]        old_q;
	logic [1:0]         status_q;
	logic [16:0]        frac_q;
	logic signed [49:0] prod_q;
	logic signed [31:0] share_q;
	result_t            result_q;
	logic [63:0]        delta;
	logic               hit;
	logic               issue;
	logic [49:0]        prod_abs;
	logic [10:0]        cpus;
	logic               div_start;
	logic [31:0]        div_dividend;
	logic [31:0]        div_rem;
	logic [31:0]        div_divisor;
	logic [5:0]         div_steps;
	logic [31:0]        div_quo;
	logic               div_idle;

	// Search and delta logic
	always_comb begin
		issue    = cmd.search_step && (idx_q < fill_q);
		hit      = rd_vld_s1 && (rd_data_s1[94:64] == tid_q);
		delta    = now_q - old_q;
		prod_abs = prod_q[49] ? 50'(-prod_q) : 50'(prod_q);
		cpus     = (cpu_count == '0) ? 11'd1 : cpu_count;
	end

	// Divider operands for the two divisions
	always_comb begin
		div_start = cmd.frac_div_start || cmd.share_div_start;
		if (cmd.share_div_start) begin
			div_dividend = prod_abs[47:16];
			div_rem      = '0;
			div_divisor  = {21'd0, cpus};
			div_steps    = 6'd32;
		end else begin
			div_dividend = '0;
			div_rem      = delta[31:0];
			div_divisor  = runtime_per_interval;
			div_steps    = 6'd16;
		end
	end

	trs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.rem_init (div_rem),
		.divisor  (div_divisor),
		.steps    (div_steps),
		.quotient (div_quo),
		.idle     (div_idle)
	);

	// Slot table memory
	always_ff @(posedge clk) begin
		if (cmd.place && status_q != STATUS_FULL) begin
			mem[slot_q] <= {tid_q, now_q};
		end
		rd_data_s1 <= mem[idx_q[AW-1:0]];
		rd_addr_s1 <= idx_q[AW-1:0];
	end

	// Search control: scan index, read valid and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			rd_vld_s1 <= 1'b0;
			fill_q    <= '0;
		end else begin
			if (cmd.load_in) begin
				idx_q     <= '0;
				rd_vld_s1 <= 1'b0;
			end else begin
				rd_vld_s1 <= issue;
				if (issue) begin
					idx_q <= idx_q + CW'(1);
				end
			end
			if (cmd.place && status_q == STATUS_NEW) begin
				fill_q <= fill_q + CW'(1);
			end
		end
	end

	// Hold the sample and work registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			tid_q    <= sample.thread_id;
			now_q    <= sample.runtime_now;
			energy_q <= sample.energy_delta;
		end
		if (cmd.search_step) begin
			if (hit) begin
				slot_q   <= rd_addr_s1;
				old_q    <= rd_data_s1[63:0];
				status_q <= STATUS_FOUND;
			end else begin
				slot_q   <= fill_q[AW-1:0];
				old_q    <= '0;
				status_q <= (fill_q == SLOTS_C) ? STATUS_FULL : STATUS_NEW;
			end
		end
		if (cmd.frac_one) begin
			frac_q <= ONE_Q16;
		end else if (cmd.frac_take) begin
			frac_q <= {1'b0, div_quo[15:0]};
		end
		if (cmd.mul) begin
			prod_q <= $signed({1'b0, frac_q}) * energy_q;
		end
		if (cmd.share_take) begin
			share_q <= prod_q[49] ? -$signed(div_quo) : $signed(div_quo);
		end
		if (cmd.out_load) begin
			result_q.status <= status_q;
			if (status_q == STATUS_FULL) begin
				result_q.busy_fraction <= '0;
				result_q.energy_share  <= '0;
				result_q.report        <= 1'b0;
			end else begin
				result_q.busy_fraction <= frac_q;
				result_q.energy_share  <= share_q;
				result_q.report        <= (frac_q >= report_threshold);
			end
		end
	end

	assign sts.found     = hit;
	assign sts.exhausted = !rd_vld_s1 && (idx_q == fill_q);
	assign sts.full      = (status_q == STATUS_FULL);
	assign sts.delta_ge  = (delta >= {32'd0, runtime_per_interval});
	assign sts.div_idle  = div_idle;
	assign result        = result_q;
endmodule
`default_nettype wire

[hw/rtl/trs_ctrl.sv]
// Sequencer of the energy share block.
`default_nettype none
module trs_ctrl import trs_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic sample_valid,
	output logic      sample_ready,
	output logic      result_valid,
	input  wire logic result_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);
	state_t state_q;
	state_t state_d;
	logic   out_vld_q;
	logic   out_free;

	assign out_free = !out_vld_q || result_ready;

	// State register and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_vld_q <= 1'b1;
			end else if (result_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Next state and commands
	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		sample_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				sample_ready = 1'b1;
				if (sample_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				cmd.search_step = 1'b1;
				if (sts.found || sts.exhausted) begin
					state_d = ST_PLACE;
				end
			end
			ST_PLACE: begin
				cmd.place = 1'b1;
				if (sts.full) begin
					state_d = ST_DONE;
				end else if (sts.delta_ge) begin
					cmd.frac_one = 1'b1;
					state_d      = ST_MUL;
				end else begin
					cmd.frac_div_start = 1'b1;
					state_d            = ST_FRAC_DIV;
				end
			end
			ST_FRAC_DIV: begin
				if (sts.div_idle) begin
					cmd.frac_take = 1'b1;
					state_d       = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_SHARE_GO;
			end
			ST_SHARE_GO: begin
				cmd.share_div_start = 1'b1;
				state_d             = ST_SHARE_DIV;
			end
			ST_SHARE_DIV: begin
				if (sts.div_idle) begin
					cmd.share_take = 1'b1;
					state_d        = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign result_valid = out_vld_q;
endmodule
`default_nettype wire

[hw/rtl/trs_checker.sv]
// Port checker of the energy share block and its bind.
`default_nettype none
`include "thread_runtime_energy_share_defines.svh"
module trs_checker import trs_pkg::*; (
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    result_valid,
	input wire logic    result_ready,
	input wire result_t result
);
	`TRS_ASSERT_HOLD(a_result_hold, clk, arst_n, result_valid, result_ready, result, "result beat dropped or changed while stalled")
	`TRS_ASSERT(a_status_code, clk, arst_n, result_valid |-> (result.status == STATUS_FOUND || result.status == STATUS_NEW || result.status == STATUS_FULL), "undefined status code")
	`TRS_ASSERT(a_full_zero, clk, arst_n, (result_valid && result.status == STATUS_FULL) |-> (result.busy_fraction == '0 && result.energy_share == '0 && !result.report), "full table result not zero")
	`TRS_ASSERT(a_frac_range, clk, arst_n, result_valid |-> (result.busy_fraction <= ONE_Q16), "busy fraction above one")
endmodule

bind thread_runtime_energy_share trs_checker u_trs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);
`default_nettype wire
